// ----- rtl/framebuffer_readout_unpacker_unit_macros.svh -----
// Assertion macros for the RTL of the scanout unpacker.
`ifndef FRAMEBUFFER_READOUT_UNPACKER_UNIT_MACROS_SVH
`define FRAMEBUFFER_READOUT_UNPACKER_UNIT_MACROS_SVH

// Same-cycle implication, quiet while reset is high
`define FRU_ASSERT_NOW(label, clk_i, rst_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is high
`define FRU_ASSERT_NEXT(label, clk_i, rst_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fru_pkg.sv -----
`default_nettype none

package fru_pkg;

  // Address walk width and the width of the announced read address
  localparam int ADDR_BITS = 24;
  localparam int NRA_W     = 24;

  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;
  localparam int PPL_W     = 12;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 10;
  localparam int GAP_W     = 14;
  localparam int BPP_W     = 3;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WORDS    = 3'd0,
    REG_LINE_COUNT    = 3'd1,
    REG_LINE_MODULUS  = 3'd2,
    REG_PIXEL_FORMAT  = 3'd3,
    REG_CONCAT_BITS   = 3'd4,
    REG_START_ADDRESS = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    FMT_RGB555 = 2'd0,
    FMT_RGB565 = 2'd1,
    FMT_RGB888 = 2'd2,
    FMT_0888   = 2'd3
  } fmt_t;

  // How the back end takes a word apart
  typedef enum logic [2:0] {
    KIND_555,
    KIND_565,
    KIND_888_EVEN,
    KIND_888_ODD,
    KIND_0888
  } kind_t;

  // Registered configuration and the values derived from it
  typedef struct packed {
    logic [ROW_W-1:0]     line_count;
    fmt_t                 fmt;
    logic [2:0]           concat;
    logic [CFG_DAT_W-1:0] start_address;
    logic [PPL_W-1:0]     ppl;
    logic [BPP_W-1:0]     bpp;
    logic [ADDR_BITS-1:0] step_eol;
    logic                 zero_size;
    logic                 settling;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    kind_t             kind;
    logic              eol;
    logic              eof;
    logic [NRA_W-1:0]  next_addr;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // x / 3 by reciprocal multiply, exact for x below 2^16
  function automatic logic [PPL_W-1:0] div3(input logic [12:0] x);
    logic [28:0] prod;
    prod = 29'(x) * 29'd43691;
    return prod[28:17];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/framebuffer_readout_unpacker_unit.sv -----
`default_nettype none
`include "framebuffer_readout_unpacker_unit_macros.svh"

// Scanout unpacker: each input beat carries the memory word read at the
// address announced with the previous pixel (or at start_address when tuser
// marks a new frame); each output beat carries one pixel as three bytes,
// the next address to read, tlast at line end and tuser at frame end. The
// block sustains one pixel per clock while the queue has room and the
// output is not held off; each pixel goes through the address walk into the
// two-entry queue and then through the unpacker into the output register.
// The address and counter update of one pixel sets the walk for the next.
// Input tready drops for one cycle after each configuration write and
// for the first cycle after reset while the derived line length and
// line-end step are refreshed.
module framebuffer_readout_unpacker_unit (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire  [31:0]                     s_axis_tdata,  // [31:0] vram_word
  input  wire                             s_axis_tuser,  // [0] new_frame
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // [7:0] channel_first, [15:8] channel_second, [23:16] channel_third,
  // [47:24] next_read_address
  output logic [47:0]                     m_axis_tdata,
  output logic                            m_axis_tlast,  // end_of_line
  output logic                            m_axis_tuser,  // [0] end_of_frame
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [fru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [fru_pkg::CFG_DAT_W-1:0]   cfg_data
);

  fru_pkg::cfg_t                 cfg;
  fru_pkg::q_entry_t             push_entry;
  fru_pkg::q_entry_t             head;
  fru_pkg::q_status_t            q_stat;
  logic                          push;
  logic                          pop;
  logic [7:0]                    ch_first;
  logic [7:0]                    ch_second;
  logic [7:0]                    ch_third;
  logic [fru_pkg::NRA_W-1:0]     next_addr;

  fru_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fru_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_word      (s_axis_tdata),
    .in_new_frame (s_axis_tuser),
    .q_stat       (q_stat),
    .push         (push),
    .entry        (push_entry)
  );

  fru_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  fru_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .ch_first      (ch_first),
    .ch_second     (ch_second),
    .ch_third      (ch_third),
    .out_eol       (m_axis_tlast),
    .out_eof       (m_axis_tuser),
    .out_next_addr (next_addr)
  );

  assign m_axis_tdata = {next_addr, ch_third, ch_second, ch_first};

  // Frame end is always also a line end
  `FRU_ASSERT_NOW(a_eof_with_eol, clk, rst, m_axis_tvalid && m_axis_tuser,
                  m_axis_tlast, "frame end without line end")
  // A configuration write holds off input for the following cycle
  `FRU_ASSERT_NEXT(a_cfg_holds_input, clk, rst, cfg_valid && cfg_ready,
                   !s_axis_tready, "input taken right after a register write")
  // With the queue empty, a taken output beat leaves the output register empty
  `FRU_ASSERT_NEXT(a_drain, clk, rst, m_axis_tvalid && m_axis_tready && q_stat.empty,
                   !m_axis_tvalid, "output beat repeated")

endmodule

`default_nettype wire

// ----- rtl/fru_cfg.sv -----
`default_nettype none

module fru_cfg (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [fru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [fru_pkg::CFG_DAT_W-1:0]    cfg_data,
  output fru_pkg::cfg_t                    cfg
);

  logic [9:0]                    line_words;
  logic [9:0]                    line_count;
  logic [9:0]                    line_modulus;
  logic [1:0]                    pixel_format;
  logic [2:0]                    concat_bits;
  logic [fru_pkg::CFG_DAT_W-1:0] start_address;
  logic                          wr;

  fru_pkg::cfg_t                 cfg_next;
  logic [10:0]                   lw1;
  logic [9:0]                    lm1;
  logic [fru_pkg::GAP_W-1:0]     gap;
  logic [fru_pkg::GAP_W-1:0]     gap4;
  logic [fru_pkg::PPL_W-1:0]     q3;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_words    <= '0;
      line_count    <= '0;
      line_modulus  <= '0;
      pixel_format  <= '0;
      concat_bits   <= '0;
      start_address <= '0;
    end else if (wr) begin
      case (fru_pkg::reg_idx_t'(cfg_index))
        fru_pkg::REG_LINE_WORDS:    line_words    <= cfg_data[9:0];
        fru_pkg::REG_LINE_COUNT:    line_count    <= cfg_data[9:0];
        fru_pkg::REG_LINE_MODULUS:  line_modulus  <= cfg_data[9:0];
        fru_pkg::REG_PIXEL_FORMAT:  pixel_format  <= cfg_data[1:0];
        fru_pkg::REG_CONCAT_BITS:   concat_bits   <= cfg_data[2:0];
        fru_pkg::REG_START_ADDRESS: start_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // Derive pixels per line, bytes per pixel and the line-end step
  always_comb begin
    lw1  = 11'(line_words) + 11'd1;
    lm1  = line_modulus - 10'd1;
    gap4 = {2'b00, line_modulus, 2'b00} - 14'd4;
    q3   = fru_pkg::div3({1'b0, lm1, 2'b00});
    cfg_next               = '0;
    cfg_next.line_count    = line_count;
    cfg_next.fmt           = fru_pkg::fmt_t'(pixel_format);
    cfg_next.concat        = concat_bits;
    cfg_next.start_address = start_address;
    cfg_next.zero_size     = (line_words == '0) || (line_count == '0);
    // Hold input off while the derived values catch up with the registers
    cfg_next.settling      = wr || rst;
    case (fru_pkg::fmt_t'(pixel_format))
      fru_pkg::FMT_RGB555, fru_pkg::FMT_RGB565: begin
        cfg_next.bpp = 3'd2;
        cfg_next.ppl = {lw1[10:0], 1'b0};
        gap          = gap4;
      end
      fru_pkg::FMT_RGB888: begin
        cfg_next.bpp = 3'd3;
        cfg_next.ppl = fru_pkg::div3({lw1, 2'b00});
        if (line_modulus == '0) begin
          gap = -14'd3;
        end else begin
          gap = 14'(q3) + {1'b0, q3, 1'b0};
        end
      end
      default: begin
        cfg_next.bpp = 3'd4;
        cfg_next.ppl = 12'(lw1);
        gap          = gap4;
      end
    endcase
    cfg_next.step_eol = fru_pkg::ADDR_BITS'(cfg_next.bpp)
                      + {{(fru_pkg::ADDR_BITS-fru_pkg::GAP_W){gap[fru_pkg::GAP_W-1]}}, gap};
  end

  // Refresh the derived set every cycle
  always_ff @(posedge clk) begin
    cfg <= cfg_next;
  end

endmodule

`default_nettype wire

// ----- rtl/fru_front.sv -----
`default_nettype none

module fru_front (
  input  wire                                 clk,
  input  wire                                 rst,
  input  fru_pkg::cfg_t                       cfg,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [fru_pkg::WORD_W-1:0]          in_word,
  input  wire                                 in_new_frame,
  input  fru_pkg::q_status_t                  q_stat,
  output logic                                push,
  output fru_pkg::q_entry_t                   entry
);

  logic [fru_pkg::ADDR_BITS-1:0] pixel_address;
  logic [fru_pkg::COL_W-1:0]     column_count;
  logic [fru_pkg::ROW_W-1:0]     row_count;
  logic                          frame_active;

  logic [fru_pkg::ADDR_BITS-1:0] pixel_address_next;
  logic [fru_pkg::COL_W-1:0]     column_count_next;
  logic [fru_pkg::ROW_W-1:0]     row_count_next;
  logic                          frame_active_next;

  logic [fru_pkg::ADDR_BITS-1:0] addr_eff;
  logic [fru_pkg::ADDR_BITS-1:0] start;
  logic [fru_pkg::COL_W-1:0]     col_eff;
  logic [fru_pkg::ROW_W-1:0]     row_eff;
  logic                          active_eff;
  logic                          accept;
  logic                          produce;
  logic                          eol;
  logic                          eof;

  assign in_ready = !q_stat.full && !cfg.settling;
  assign accept   = in_valid && in_ready;
  assign push     = accept && produce;

  // Classify the beat and step the address walk
  always_comb begin
    start      = fru_pkg::ADDR_BITS'(cfg.start_address);
    addr_eff   = in_new_frame ? start : pixel_address;
    col_eff    = in_new_frame ? '0 : column_count;
    row_eff    = in_new_frame ? '0 : row_count;
    active_eff = in_new_frame || frame_active;
    produce    = active_eff && !cfg.zero_size;
    eol        = (12'(col_eff) + 12'd1) >= cfg.ppl;
    eof        = eol && (row_eff >= cfg.line_count);

    pixel_address_next = addr_eff;
    column_count_next  = col_eff;
    row_count_next     = row_eff;
    frame_active_next  = active_eff;
    if (produce) begin
      if (eof) begin
        pixel_address_next = start;
        column_count_next  = '0;
        row_count_next     = '0;
        frame_active_next  = 1'b0;
      end else if (eol) begin
        pixel_address_next = addr_eff + cfg.step_eol;
        column_count_next  = '0;
        row_count_next     = row_eff + 10'd1;
      end else begin
        pixel_address_next = addr_eff + fru_pkg::ADDR_BITS'(cfg.bpp);
        column_count_next  = col_eff + 11'd1;
      end
    end

    entry.word = in_word;
    entry.eol  = eol;
    entry.eof  = eof;
    case (cfg.fmt)
      fru_pkg::FMT_RGB555: entry.kind = fru_pkg::KIND_555;
      fru_pkg::FMT_RGB565: entry.kind = fru_pkg::KIND_565;
      fru_pkg::FMT_RGB888: entry.kind = addr_eff[0] ? fru_pkg::KIND_888_ODD
                                                     : fru_pkg::KIND_888_EVEN;
      default:             entry.kind = fru_pkg::KIND_0888;
    endcase
    // Packed 888 at an odd address reads the word one byte below
    entry.next_addr = fru_pkg::NRA_W'(pixel_address_next);
    if (cfg.fmt == fru_pkg::FMT_RGB888) begin
      entry.next_addr[0] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_address <= '0;
      column_count  <= '0;
      row_count     <= '0;
      frame_active  <= 1'b0;
    end else if (accept) begin
      pixel_address <= pixel_address_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      frame_active  <= frame_active_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fru_queue.sv -----
`default_nettype none

module fru_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  fru_pkg::q_entry_t   push_entry,
  input  wire                 pop,
  output fru_pkg::q_entry_t   head,
  output fru_pkg::q_status_t  stat
);

  fru_pkg::q_entry_t           slots [fru_pkg::QDEPTH];
  logic [fru_pkg::QPTR_W-1:0]  wr_ptr;
  logic [fru_pkg::QPTR_W-1:0]  rd_ptr;
  logic [fru_pkg::QCNT_W-1:0]  count;
  logic [fru_pkg::QCNT_W-1:0]  count_next;

  assign stat.full  = (count == fru_pkg::QCNT_W'(fru_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign head       = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + fru_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - fru_pkg::QCNT_W'(1);
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fru_back.sv -----
`default_nettype none

module fru_back (
  input  wire                           clk,
  input  wire                           rst,
  input  fru_pkg::cfg_t                 cfg,
  input  fru_pkg::q_entry_t             head,
  input  fru_pkg::q_status_t            q_stat,
  output logic                          pop,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [7:0]                    ch_first,
  output logic [7:0]                    ch_second,
  output logic [7:0]                    ch_third,
  output logic                          out_eol,
  output logic                          out_eof,
  output logic [fru_pkg::NRA_W-1:0]     out_next_addr
);

  logic [7:0]  c1;
  logic [7:0]  c2;
  logic [7:0]  c3;
  logic [15:0] h;
  logic [7:0]  cc;
  logic [7:0]  cc_half;

  assign pop = !q_stat.empty && (!out_valid || out_ready);

  // Unpack the pixel according to its kind
  always_comb begin
    h       = head.word[15:0];
    cc      = 8'(cfg.concat);
    cc_half = 8'(cfg.concat[2:1]);
    case (head.kind)
      fru_pkg::KIND_555: begin
        c1 = {h[4:0], 3'b000} + cc;
        c2 = {h[9:5], 3'b000} + cc;
        c3 = {h[14:10], 3'b000} + cc;
      end
      fru_pkg::KIND_565: begin
        c1 = {h[4:0], 3'b000} + cc;
        c2 = {h[10:5], 2'b00} + cc_half;
        c3 = {h[15:11], 3'b000} + cc;
      end
      fru_pkg::KIND_888_EVEN: begin
        c1 = head.word[15:8];
        c2 = head.word[23:16];
        c3 = head.word[31:24];
      end
      default: begin
        c1 = head.word[7:0];
        c2 = head.word[15:8];
        c3 = head.word[23:16];
      end
    endcase
  end

  // Output register: load on pop, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ch_first      <= c1;
      ch_second     <= c2;
      ch_third      <= c3;
      out_eol       <= head.eol;
      out_eof       <= head.eof;
      out_next_addr <= head.next_addr;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_framebuffer_readout_unpacker_unit.sv -----
`default_nettype none

module tb_framebuffer_readout_unpacker_unit;
  import fru_pkg::*;

  // One pixel beat as the block should present it
  typedef struct {
    logic [7:0]       ch_first;
    logic [7:0]       ch_second;
    logic [7:0]       ch_third;
    logic             eol;
    logic             eof;
    logic [NRA_W-1:0] next_addr;
  } scan_pixel_t;

  // Mirror of the scanout walk plus the queue of pixels still owed
  class scanout_scoreboard;
    logic [9:0]           line_words;
    logic [9:0]           line_count;
    logic [9:0]           line_modulus;
    fmt_t                 fmt;
    logic [2:0]           concat;
    logic [23:0]          start_addr;
    logic [ADDR_BITS-1:0] pix_addr;
    logic [10:0]          col;
    logic [9:0]           row;
    bit                   active;
    scan_pixel_t          owed_q[$];
    int                   mismatches;

    function new();
      line_words   = '0;
      line_count   = '0;
      line_modulus = '0;
      fmt          = FMT_RGB555;
      concat       = '0;
      start_addr   = '0;
      pix_addr     = '0;
      col          = '0;
      row          = '0;
      active       = 1'b0;
      mismatches   = 0;
    endfunction

    function void write_reg(input reg_idx_t idx, input logic [23:0] v);
      case (idx)
        REG_LINE_WORDS:    line_words   = v[9:0];
        REG_LINE_COUNT:    line_count   = v[9:0];
        REG_LINE_MODULUS:  line_modulus = v[9:0];
        REG_PIXEL_FORMAT:  fmt          = fmt_t'(v[1:0]);
        REG_CONCAT_BITS:   concat       = v[2:0];
        REG_START_ADDRESS: start_addr   = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Advance the walk by one input word; return 1 when a pixel is owed
    function bit note_word(input logic [31:0] w, input bit nf);
      int          ppl;
      int          gap;
      int          bpp;
      logic [15:0] half;
      scan_pixel_t px;
      half = w[15:0];
      if (nf) begin
        pix_addr = start_addr;
        col      = '0;
        row      = '0;
        active   = 1'b1;
      end
      if (!active || line_words == 0 || line_count == 0) return 1'b0;

      ppl = (int'(line_words) + 1) * 2;
      gap = (int'(line_modulus) - 1) * 2;
      case (fmt)
        FMT_RGB555: begin
          bpp          = 2;
          px.ch_first  = {half[4:0], 3'b000} + concat;
          px.ch_second = {half[9:5], 3'b000} + concat;
          px.ch_third  = {half[14:10], 3'b000} + concat;
        end
        FMT_RGB565: begin
          bpp          = 2;
          px.ch_first  = {half[4:0], 3'b000} + concat;
          px.ch_second = {half[10:5], 2'b00} + (concat >> 1);
          px.ch_third  = {half[15:11], 3'b000} + concat;
        end
        FMT_RGB888: begin
          bpp = 3;
          ppl = (ppl * 2) / 3;
          gap = (gap * 2) / 3;
          // odd pixel address: the word was fetched one byte lower
          if (pix_addr[0]) begin
            px.ch_first  = w[7:0];
            px.ch_second = w[15:8];
            px.ch_third  = w[23:16];
          end else begin
            px.ch_first  = w[15:8];
            px.ch_second = w[23:16];
            px.ch_third  = w[31:24];
          end
        end
        default: begin
          bpp          = 4;
          ppl          = ppl / 2;
          gap          = gap / 2;
          px.ch_first  = w[7:0];
          px.ch_second = w[15:8];
          px.ch_third  = w[23:16];
        end
      endcase

      px.eol   = (int'(col) + 1 >= ppl);
      px.eof   = px.eol && (row >= line_count);
      pix_addr = pix_addr + ADDR_BITS'(bpp);
      if (px.eol) begin
        pix_addr = pix_addr + ADDR_BITS'(gap * bpp);
        col      = '0;
        row      = row + 10'd1;
      end else begin
        col = col + 11'd1;
      end
      if (px.eof) begin
        active   = 1'b0;
        pix_addr = start_addr;
        col      = '0;
        row      = '0;
      end
      px.next_addr = pix_addr;
      if (fmt == FMT_RGB888 && pix_addr[0]) px.next_addr = pix_addr - 1'b1;
      owed_q = {owed_q, px};
      return 1'b1;
    endfunction

    // Compare one output beat with the oldest owed pixel
    function void check_beat(input logic [47:0] d, input logic eol, input logic eof);
      scan_pixel_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel beat: data=%012h eol=%0b eof=%0b", d, eol, eof);
        return;
      end
      want = owed_q.pop_front();
      if (d[7:0] !== want.ch_first || d[15:8] !== want.ch_second ||
          d[23:16] !== want.ch_third || d[47:24] !== want.next_addr ||
          eol !== want.eol || eof !== want.eof) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("pixel mismatch: want %02h %02h %02h eol=%0b eof=%0b addr=%06h",
                   want.ch_first, want.ch_second, want.ch_third, want.eol, want.eof,
                   want.next_addr);
          $display("                got  %02h %02h %02h eol=%0b eof=%0b addr=%06h",
                   d[7:0], d[15:8], d[23:16], eol, eof, d[47:24]);
        end
      end
    endfunction
  endclass

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [47:0]          m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_DAT_W-1:0] cfg_data      = '0;
  logic                 steady        = 1'b0;

  scanout_scoreboard sb = new();
  int                counted;
  int                dir_k;

  framebuffer_readout_unpacker_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // Stall the output side at random, except in the steady stretch
  always @(posedge clk) begin
    if (steady) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(99) >= 37);
  end

  // Check every accepted output beat
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // Present one memory word and hold it until the block takes the beat
  task automatic feed_word(input logic [31:0] w, input bit nf);
    while (!steady && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= nf;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    void'(sb.note_word(w, nf));
    counted++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [23:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  // Drop the input valid, drain owed pixels and let the pipe empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Program every register, then run a few words from a frame start
  task automatic directed_run(input logic [9:0] lw, input logic [9:0] lc,
                              input logic [9:0] lm, input fmt_t f,
                              input logic [2:0] cc, input logic [23:0] sa,
                              input int n);
    logic [31:0] pat [4];
    pat = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 32'hA5A5_5A5A};
    write_reg(REG_LINE_WORDS, 24'(lw));
    write_reg(REG_LINE_COUNT, 24'(lc));
    write_reg(REG_LINE_MODULUS, 24'(lm));
    write_reg(REG_PIXEL_FORMAT, 24'(f));
    write_reg(REG_CONCAT_BITS, 24'(cc));
    write_reg(REG_START_ADDRESS, sa);
    cfg_valid <= 1'b0;
    for (int i = 0; i < n; i++) begin
      feed_word(pat[dir_k % 4], i == 0);
      dir_k++;
    end
    settle();
  endtask

  function automatic logic [9:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 10'($urandom_range(1, 4));
    if (r < 78) return 10'd0;
    if (r < 88) return 10'd1023;
    return 10'($urandom_range(1023));
  endfunction

  function automatic logic [9:0] pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 10'd0;
    if (r < 35) return 10'd1023;
    if (r < 50) return 10'd1;
    return 10'($urandom_range(1023));
  endfunction

  function automatic logic [23:0] pick_start();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 24'h000000;
    if (r < 40) return 24'hFFFFFF;
    return 24'($urandom);
  endfunction

  // Rewrite a random subset of the registers
  task automatic random_settings();
    if ($urandom_range(1)) write_reg(REG_LINE_WORDS, 24'(pick_size()));
    if ($urandom_range(1)) write_reg(REG_LINE_COUNT, 24'(pick_size()));
    if ($urandom_range(1)) write_reg(REG_LINE_MODULUS, 24'(pick_gap()));
    if ($urandom_range(1)) write_reg(REG_PIXEL_FORMAT, 24'($urandom_range(3)));
    if ($urandom_range(1)) write_reg(REG_CONCAT_BITS, 24'($urandom_range(7)));
    if ($urandom_range(1)) write_reg(REG_START_ADDRESS, pick_start());
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit nf;
    int n;
    counted = 0;
    dir_k   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Idle and zero size straight out of reset: no pixels
    feed_word(32'h0000_0000, 1'b0);
    feed_word(32'hFFFF_FFFF, 1'b1);
    settle();

    // One short run per format, covering odd 888 addresses, negative gaps,
    // address wrap and the idle word after a frame end
    directed_run(10'd1, 10'd1, 10'd1, FMT_RGB555, 3'd0, 24'h000100, 4);
    directed_run(10'd1, 10'd1, 10'd0, FMT_RGB565, 3'd7, 24'hFFFFFE, 5);
    directed_run(10'd1, 10'd1, 10'd1023, FMT_RGB888, 3'd3, 24'h000101, 5);
    directed_run(10'd1, 10'd1, 10'd0, FMT_0888, 3'd5, 24'hFFFFFC, 4);

    // Random phases: mostly whole frames, some stray frame restarts;
    // large sizes leave frames open so the next settings cut them short
    while (counted < 1650) begin
      steady <= (counted >= 700 && counted < 1000);
      random_settings();
      n = $urandom_range(4, 48);
      for (int i = 0; i < n; i++) begin
        if (!sb.active) nf = ($urandom_range(9) != 0);
        else nf = ($urandom_range(39) == 0);
        feed_word($urandom, nf);
      end
      settle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Give up well past the slowest plausible run
  initial begin
    #(400_000 * 8);
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/fru_pkg.sv
rtl/fru_cfg.sv
rtl/fru_front.sv
rtl/fru_queue.sv
rtl/fru_back.sv
rtl/framebuffer_readout_unpacker_unit.sv
tb/tb_framebuffer_readout_unpacker_unit.sv
